// File: hw/rtl/nor_flash_command_sequencer_assert.svh
// Assertion macros for the NOR flash command sequencer.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef NOR_FLASH_COMMAND_SEQUENCER_ASSERT_SVH
`define NOR_FLASH_COMMAND_SEQUENCER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define NFCS_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define NFCS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/nfcs_pkg.sv
// Shared types, codes and the bus cycle table of the NOR flash command sequencer.
// No dependencies; every other RTL file of the block except the assertion header imports it.
package nfcs_pkg;

    localparam int ADDR_W   = 17;
    localparam int BYTE_W   = 8;
    localparam int SECTOR_W = 8;
    localparam int KIND_W   = 3;
    localparam int WAIT_W   = 18;
    localparam int STEP_W   = 3;
    localparam int LAST_SECTOR_W = 5;

    // Request kinds on the input channel.
    localparam logic [KIND_W-1:0] KIND_READ         = 3'd0;
    localparam logic [KIND_W-1:0] KIND_PROGRAM      = 3'd1;
    localparam logic [KIND_W-1:0] KIND_SECTOR_ERASE = 3'd2;
    localparam logic [KIND_W-1:0] KIND_CHIP_ERASE   = 3'd3;
    localparam logic [KIND_W-1:0] KIND_READ_ID      = 3'd4;

    // Cycle kinds on the output channel.
    localparam logic [1:0] CK_WRITE  = 2'd0;
    localparam logic [1:0] CK_READ   = 2'd1;
    localparam logic [1:0] CK_REJECT = 2'd2;

    // Capture tags for read cycles.
    localparam logic [1:0] TAG_NONE      = 2'd0;
    localparam logic [1:0] TAG_READ_DATA = 2'd1;
    localparam logic [1:0] TAG_SW_ID     = 2'd2;
    localparam logic [1:0] TAG_DEV_ID    = 2'd3;

    // JEDEC unlock addresses and command bytes.
    localparam logic [ADDR_W-1:0] UNLOCK_A = 17'h05555;
    localparam logic [ADDR_W-1:0] UNLOCK_B = 17'h02AAA;
    localparam logic [ADDR_W-1:0] ID_ADDR_SW  = 17'h00000;
    localparam logic [ADDR_W-1:0] ID_ADDR_DEV = 17'h00001;
    localparam logic [BYTE_W-1:0] CMD_UNLOCK_1  = 8'hAA;
    localparam logic [BYTE_W-1:0] CMD_UNLOCK_2  = 8'h55;
    localparam logic [BYTE_W-1:0] CMD_PROGRAM   = 8'hA0;
    localparam logic [BYTE_W-1:0] CMD_ERASE     = 8'h80;
    localparam logic [BYTE_W-1:0] CMD_CHIP      = 8'h10;
    localparam logic [BYTE_W-1:0] CMD_SECTOR    = 8'h30;
    localparam logic [BYTE_W-1:0] CMD_ID_ENTRY  = 8'h90;
    localparam logic [BYTE_W-1:0] CMD_ID_EXIT   = 8'hF0;

    // Waits after each bus access, in microseconds.
    localparam logic [WAIT_W-1:0] WAIT_NONE    = 18'd0;
    localparam logic [WAIT_W-1:0] WAIT_BUS     = 18'd1;
    localparam logic [WAIT_W-1:0] WAIT_PROGRAM = 18'd20;
    localparam logic [WAIT_W-1:0] WAIT_SECTOR  = 18'd50000;
    localparam logic [WAIT_W-1:0] WAIT_CHIP    = 18'd200000;

    // Byte address of the single configuration register.
    localparam logic [2:0] REG_LAST_SECTOR = 3'd0;

    // Operation after classification by the front end.
    typedef enum logic [2:0] {
        OP_READ,
        OP_PROGRAM,
        OP_SECTOR_ERASE,
        OP_CHIP_ERASE,
        OP_READ_ID,
        OP_REJECT
    } op_t;

    // One classified request travelling through the queue.
    typedef struct packed {
        op_t               op;
        logic [ADDR_W-1:0] addr;
        logic [BYTE_W-1:0] data;
    } desc_t;

    // One bus cycle as delivered on the output channel.
    typedef struct packed {
        logic [1:0]        cycle_kind;
        logic [ADDR_W-1:0] bus_address;
        logic [BYTE_W-1:0] bus_data;
        logic [1:0]        capture_tag;
        logic [WAIT_W-1:0] wait_us;
        logic              last_cycle;
    } cyc_t;

    // Sequencer status seen by the top level.
    typedef struct packed {
        logic              busy;
        logic [STEP_W-1:0] step;
        op_t               op;
    } back_status_t;

    function automatic cyc_t bus_write(logic [ADDR_W-1:0] addr, logic [BYTE_W-1:0] data,
                                       logic [WAIT_W-1:0] wait_time, logic last);
        cyc_t c;
        c.cycle_kind  = CK_WRITE;
        c.bus_address = addr;
        c.bus_data    = data;
        c.capture_tag = TAG_NONE;
        c.wait_us     = wait_time;
        c.last_cycle  = last;
        return c;
    endfunction

    function automatic cyc_t bus_read(logic [ADDR_W-1:0] addr, logic [1:0] tag,
                                      logic last);
        cyc_t c;
        c.cycle_kind  = CK_READ;
        c.bus_address = addr;
        c.bus_data    = '0;
        c.capture_tag = tag;
        c.wait_us     = WAIT_BUS;
        c.last_cycle  = last;
        return c;
    endfunction

    function automatic cyc_t reject_cycle();
        cyc_t c;
        c.cycle_kind  = CK_REJECT;
        c.bus_address = '0;
        c.bus_data    = '0;
        c.capture_tag = TAG_NONE;
        c.wait_us     = WAIT_NONE;
        c.last_cycle  = 1'b1;
        return c;
    endfunction

    // The five writes that open both erase sequences.
    function automatic cyc_t erase_unlock(logic [STEP_W-1:0] step);
        cyc_t c;
        unique case (step)
            3'd0:    c = bus_write(UNLOCK_A, CMD_UNLOCK_1, WAIT_BUS, 1'b0);
            3'd1:    c = bus_write(UNLOCK_B, CMD_UNLOCK_2, WAIT_BUS, 1'b0);
            3'd2:    c = bus_write(UNLOCK_A, CMD_ERASE, WAIT_BUS, 1'b0);
            3'd3:    c = bus_write(UNLOCK_A, CMD_UNLOCK_1, WAIT_BUS, 1'b0);
            default: c = bus_write(UNLOCK_B, CMD_UNLOCK_2, WAIT_BUS, 1'b0);
        endcase
        return c;
    endfunction

    // Bus cycle number step of a classified operation.
    function automatic cyc_t build_cycle(op_t op, logic [STEP_W-1:0] step,
                                         logic [ADDR_W-1:0] addr, logic [BYTE_W-1:0] data);
        cyc_t c;
        unique case (op)
            OP_READ: c = bus_read(addr, TAG_READ_DATA, 1'b1);
            OP_PROGRAM: begin
                unique case (step)
                    3'd0:    c = bus_write(UNLOCK_A, CMD_UNLOCK_1, WAIT_BUS, 1'b0);
                    3'd1:    c = bus_write(UNLOCK_B, CMD_UNLOCK_2, WAIT_BUS, 1'b0);
                    3'd2:    c = bus_write(UNLOCK_A, CMD_PROGRAM, WAIT_BUS, 1'b0);
                    default: c = bus_write(addr, data, WAIT_PROGRAM, 1'b1);
                endcase
            end
            OP_SECTOR_ERASE: begin
                if (step == 3'd5)
                    c = bus_write(addr, CMD_SECTOR, WAIT_SECTOR, 1'b1);
                else
                    c = erase_unlock(step);
            end
            OP_CHIP_ERASE: begin
                if (step == 3'd5)
                    c = bus_write(UNLOCK_A, CMD_CHIP, WAIT_CHIP, 1'b1);
                else
                    c = erase_unlock(step);
            end
            OP_READ_ID: begin
                unique case (step)
                    3'd0:    c = bus_write(UNLOCK_A, CMD_UNLOCK_1, WAIT_BUS, 1'b0);
                    3'd1:    c = bus_write(UNLOCK_B, CMD_UNLOCK_2, WAIT_BUS, 1'b0);
                    3'd2:    c = bus_write(UNLOCK_A, CMD_ID_ENTRY, WAIT_PROGRAM, 1'b0);
                    3'd3:    c = bus_read(ID_ADDR_SW, TAG_SW_ID, 1'b0);
                    3'd4:    c = bus_read(ID_ADDR_DEV, TAG_DEV_ID, 1'b0);
                    3'd5:    c = bus_write(UNLOCK_A, CMD_UNLOCK_1, WAIT_BUS, 1'b0);
                    3'd6:    c = bus_write(UNLOCK_B, CMD_UNLOCK_2, WAIT_BUS, 1'b0);
                    default: c = bus_write(UNLOCK_A, CMD_ID_EXIT, WAIT_BUS, 1'b1);
                endcase
            end
            default: c = reject_cycle();
        endcase
        return c;
    endfunction

endpackage

// File: hw/rtl/nfcs_req_if.sv
// Request channel of the NOR flash command sequencer: valid, ready and one request word.
// Depends on nfcs_pkg for field widths.
interface nfcs_req_if
    import nfcs_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [KIND_W-1:0]   kind;
    logic [ADDR_W-1:0]   target_address;
    logic [BYTE_W-1:0]   write_byte;
    logic [SECTOR_W-1:0] sector_number;

    modport source (
        output valid, kind, target_address, write_byte, sector_number,
        input  ready
    );

    modport sink (
        input  valid, kind, target_address, write_byte, sector_number,
        output ready
    );
endinterface

// File: hw/rtl/nfcs_cyc_if.sv
// Bus cycle channel of the NOR flash command sequencer: valid, ready and one cycle word.
// Depends on nfcs_pkg for field widths.
interface nfcs_cyc_if
    import nfcs_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [1:0]        cycle_kind;
    logic [ADDR_W-1:0] bus_address;
    logic [BYTE_W-1:0] bus_data;
    logic [1:0]        capture_tag;
    logic [WAIT_W-1:0] wait_us;
    logic              last_cycle;

    modport source (
        output valid, cycle_kind, bus_address, bus_data, capture_tag, wait_us, last_cycle,
        input  ready
    );

    modport sink (
        input  valid, cycle_kind, bus_address, bus_data, capture_tag, wait_us, last_cycle,
        output ready
    );
endinterface

// File: hw/rtl/nfcs_front.sv
// Front end: accepts request words and classifies them into queue descriptors.
// Depends on nfcs_pkg and nfcs_req_if.
module nfcs_front
    import nfcs_pkg::*;
#(
    parameter int ADDRESS_BITS = 17,
    parameter int SECTOR_SHIFT = 12
) (
    nfcs_req_if.sink                  req,
    input  logic [LAST_SECTOR_W-1:0]  last_sector,
    input  logic                      queue_full,
    output logic                      push,
    output desc_t                     push_desc
);

    localparam logic [ADDR_W-1:0] ADDR_MASK =
        (ADDRESS_BITS >= ADDR_W) ? {ADDR_W{1'b1}} : ADDR_W'((1 << ADDRESS_BITS) - 1);
    localparam int ERASE_W = SECTOR_W + SECTOR_SHIFT;

    logic [ERASE_W-1:0] erase_wide;
    logic [ADDR_W-1:0]  erase_addr;
    logic [ADDR_W-1:0]  user_addr;
    logic               sector_ok;

    assign req.ready  = !queue_full;
    assign push       = req.valid && !queue_full;

    assign erase_wide = ERASE_W'(req.sector_number) << SECTOR_SHIFT;
    assign erase_addr = ADDR_W'(erase_wide) & ADDR_MASK;
    assign user_addr  = req.target_address & ADDR_MASK;
    assign sector_ok  = req.sector_number <= SECTOR_W'(last_sector);

    always_comb
    begin
        push_desc.addr = user_addr;
        push_desc.data = req.write_byte;
        unique case (req.kind)
            KIND_READ:    push_desc.op = OP_READ;
            KIND_PROGRAM: push_desc.op = OP_PROGRAM;
            KIND_SECTOR_ERASE:
            begin
                push_desc.op   = sector_ok ? OP_SECTOR_ERASE : OP_REJECT;
                push_desc.addr = erase_addr;
            end
            KIND_CHIP_ERASE: push_desc.op = OP_CHIP_ERASE;
            KIND_READ_ID:    push_desc.op = OP_READ_ID;
            default:         push_desc.op = OP_REJECT;
        endcase
    end

endmodule

// File: hw/rtl/nfcs_queue.sv
// Short descriptor queue between the front end and the sequencer.
// Depends on nfcs_pkg for the descriptor type.
module nfcs_queue
    import nfcs_pkg::*;
#(
    parameter int DEPTH = 2
) (
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  desc_t push_desc,
    output logic  full,
    input  logic  pop,
    output logic  head_valid,
    output desc_t head_desc
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    desc_t           slot_reg [DEPTH];
    logic [PW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   count_reg, count_next;

    assign full       = count_reg == CW'(DEPTH);
    assign head_valid = count_reg != '0;
    assign head_desc  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        unique case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_desc;
    end

endmodule

// File: hw/rtl/nfcs_back.sv
// Sequencer: steps through the bus cycles of each queued operation into an output register.
// Depends on nfcs_pkg for the descriptor, cycle table and status type.
module nfcs_back
    import nfcs_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         head_valid,
    input  desc_t        head_desc,
    output logic         pop,
    output logic         out_valid,
    input  logic         out_ready,
    output cyc_t         out_cycle,
    output back_status_t status
);

    logic              cur_valid_reg, cur_valid_next;
    desc_t             cur_desc_reg;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              out_valid_reg, out_valid_next;
    cyc_t              out_reg;

    desc_t             eff_desc;
    logic [STEP_W-1:0] eff_step;
    cyc_t              gen;
    logic              advance;

    // A held operation goes first; otherwise the queue head starts at step zero.
    assign eff_desc = cur_valid_reg ? cur_desc_reg : head_desc;
    assign eff_step = cur_valid_reg ? step_reg : '0;
    assign gen      = build_cycle(eff_desc.op, eff_step, eff_desc.addr, eff_desc.data);
    assign advance  = (cur_valid_reg || head_valid) && (!out_valid_reg || out_ready);
    assign pop      = advance && !cur_valid_reg;

    assign out_valid = out_valid_reg;
    assign out_cycle = out_reg;
    assign status.busy = cur_valid_reg;
    assign status.step = step_reg;
    assign status.op   = cur_desc_reg.op;

    always_comb
    begin
        cur_valid_next = cur_valid_reg;
        step_next      = step_reg;
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
            if (gen.last_cycle)
            begin
                cur_valid_next = 1'b0;
                step_next      = '0;
            end
            else
            begin
                cur_valid_next = 1'b1;
                step_next      = eff_step + 1'b1;
            end
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cur_valid_reg <= cur_valid_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_reg      <= gen;
            cur_desc_reg <= eff_desc;
        end
    end

endmodule

// File: hw/rtl/nor_flash_command_sequencer.sv
// Top level of the NOR flash command sequencer: configuration port, front end, queue, sequencer.
// Depends on nfcs_pkg, nfcs_req_if, nfcs_cyc_if, nfcs_front, nfcs_queue, nfcs_back
// and the assertion macros in nor_flash_command_sequencer_assert.svh.
//
//   Channel   Direction  Handshake                    Word
//   req       in         valid/ready                  kind, target_address, write_byte,
//                                                     sector_number
//   cyc       out        valid/ready                  cycle_kind, bus_address, bus_data,
//                                                     capture_tag, wait_us, last_cycle
//   apb       in         psel/penable/pwrite/pready   last_sector at byte address 0
//
// A request becomes one to eight bus cycle words, one per clock while the output is taken:
// a read or a rejected request gives one, program four, either erase six, read ID eight.
// The sequencer's step counter, which walks the cycle table, sets that rate; the next
// request's first word follows the previous one's last word with no gap if it is already queued.
// The request channel is ready while the descriptor queue has room, so requests
// keep flowing in while the sequencer works or the output stalls.
// Reset is asynchronous and active low; last_sector resets to 31.
`include "nor_flash_command_sequencer_assert.svh"

module nor_flash_command_sequencer
    import nfcs_pkg::*;
#(
    parameter int ADDRESS_BITS = 17,
    parameter int SECTOR_SHIFT = 12,
    parameter int QUEUE_DEPTH  = 2
) (
    input  logic        clk,
    input  logic        rst_n,
    nfcs_req_if.sink    req,
    nfcs_cyc_if.source  cyc,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [LAST_SECTOR_W-1:0] last_sector_reg, last_sector_next;
    logic                     cfg_write;
    logic                     reg_hit;

    logic         q_push;
    desc_t        q_push_desc;
    logic         q_full;
    logic         q_pop;
    logic         q_head_valid;
    desc_t        q_head_desc;
    cyc_t         out_cycle;
    back_status_t back_status;

    // The configuration port never inserts wait states. Only the word at byte
    // address zero holds a register; the low two address bits select a byte
    // lane and are ignored.
    assign pready    = 1'b1;
    assign reg_hit   = paddr[2] == REG_LAST_SECTOR[2];
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = reg_hit ? 32'(last_sector_reg) : '0;

    always_comb
    begin
        last_sector_next = last_sector_reg;
        if (cfg_write && reg_hit)
            last_sector_next = pwdata[LAST_SECTOR_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            last_sector_reg <= 5'd31;
        else
            last_sector_reg <= last_sector_next;
    end

    // The front end classifies each request word, including the sector range
    // check, so the sequencer only ever sees a ready-made operation.
    nfcs_front #(
        .ADDRESS_BITS (ADDRESS_BITS),
        .SECTOR_SHIFT (SECTOR_SHIFT)
    ) u_front (
        .req         (req),
        .last_sector (last_sector_reg),
        .queue_full  (q_full),
        .push        (q_push),
        .push_desc   (q_push_desc)
    );

    nfcs_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_desc  (q_push_desc),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_head_valid),
        .head_desc  (q_head_desc)
    );

    // The sequencer owns the output register; a word waiting there does not
    // block the queue from filling.
    nfcs_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (q_head_valid),
        .head_desc  (q_head_desc),
        .pop        (q_pop),
        .out_valid  (cyc.valid),
        .out_ready  (cyc.ready),
        .out_cycle  (out_cycle),
        .status     (back_status)
    );

    assign cyc.cycle_kind  = out_cycle.cycle_kind;
    assign cyc.bus_address = out_cycle.bus_address;
    assign cyc.bus_data    = out_cycle.bus_data;
    assign cyc.capture_tag = out_cycle.capture_tag;
    assign cyc.wait_us     = out_cycle.wait_us;
    assign cyc.last_cycle  = out_cycle.last_cycle;

    // Single-word operations finish in the cycle they start and are never held.
    `NFCS_ASSERT_SAME(a_single_not_held, back_status.busy, (back_status.op != OP_READ) && (back_status.op != OP_REJECT), "single-cycle operation held by sequencer")
    // A held operation has already emitted at least its first word.
    `NFCS_ASSERT_SAME(a_held_step, back_status.busy, back_status.step != '0, "held operation at step zero")
    // A rejected request is a single word with its address and wait cleared.
    `NFCS_ASSERT_SAME(a_reject_word, cyc.valid && (cyc.cycle_kind == CK_REJECT), cyc.last_cycle && (cyc.bus_address == '0) && (cyc.wait_us == '0), "malformed reject word")
    // In the cycle after a push, the queue head, sequencer or output holds a word.
    `NFCS_ASSERT_NEXT(a_push_visible, q_push, q_head_valid || back_status.busy || cyc.valid, "accepted request lost")

endmodule

// File: dv/nor_flash_command_sequencer_tb.sv
// Self-checking testbench for the NOR flash command sequencer: drives requests and the
// last_sector register, and checks every bus cycle word against an in-bench predictor or a typed word.
// Depends on nfcs_pkg, nfcs_req_if, nfcs_cyc_if and the nor_flash_command_sequencer RTL.
`timescale 1ns / 100ps

module nor_flash_command_sequencer_tb;
    import nfcs_pkg::*;

    // Erase target address is the sector number moved up by this many bits.
    localparam int ERASE_SHIFT = 12;

    // A request yields at most eight words and the sink idles at most half the time,
    // so a run as long as STALL_LIMIT with no word moved means a hang.
    localparam int STALL_LIMIT = 2000;

    // Cycles allowed after the last expected word for any stray output to show up.
    localparam int SETTLE_CYCLES = 16;

    localparam int RANDOM_PER_PHASE = 88;

    // Kind codes the block does not define; each must come back as a rejected request.
    localparam logic [KIND_W-1:0] KIND_RESERVED_LO  = 3'd5;
    localparam logic [KIND_W-1:0] KIND_RESERVED_MID = 3'd6;
    localparam logic [KIND_W-1:0] KIND_RESERVED_HI  = 3'd7;

    localparam logic [LAST_SECTOR_W-1:0] SECTOR_LIMIT_MIN = 5'd0;
    localparam logic [LAST_SECTOR_W-1:0] SECTOR_LIMIT_MAX = 5'd31;

    // Words that can be typed straight into the stimulus table.
    localparam cyc_t REJECTED_WORD = '{CK_REJECT, '0, '0, TAG_NONE, WAIT_NONE, 1'b1};
    localparam cyc_t NO_TYPED_WORD = '0;

    // One row of the directed table. Rows with typed_word set carry their single
    // expected word; all others are handed to the predictor.
    typedef struct {
        logic [KIND_W-1:0]   kind;
        logic [ADDR_W-1:0]   target_address;
        logic [BYTE_W-1:0]   write_byte;
        logic [SECTOR_W-1:0] sector_number;
        logic                typed_word;
        cyc_t                word;
    } request_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    nfcs_req_if req_if ();
    nfcs_cyc_if cyc_if ();

    nor_flash_command_sequencer u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req_if),
        .cyc     (cyc_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Bench copy of the configuration.
    logic [LAST_SECTOR_W-1:0] sector_limit = SECTOR_LIMIT_MAX;

    // Bus cycle words still owed by the block, oldest first.
    cyc_t owed_bus_cycles [$];

    // Typed expectation travelling alongside the request word it belongs to. It is
    // driven with the payload so the monitor reads the one that was accepted.
    logic row_typed = 1'b0;
    cyc_t row_word  = '0;

    // Percentages of cycles in which each side holds off.
    int sender_idle_pct   = 0;
    int receiver_idle_pct = 0;

    int mismatches      = 0;
    int requests_seen   = 0;
    int words_checked   = 0;
    int kind_seen [8]   = '{default: 0};
    int quiet_cycles    = 0;

    request_row_t directed_rows [16] = '{
        // Read at both address extremes; straight after reset.
        '{KIND_READ, 17'h00000, 8'h00, 8'h00, 1'b1,
          '{CK_READ, 17'h00000, 8'h00, TAG_READ_DATA, WAIT_BUS, 1'b1}},
        '{KIND_READ, 17'h1FFFF, 8'hFF, 8'hFF, 1'b1,
          '{CK_READ, 17'h1FFFF, 8'h00, TAG_READ_DATA, WAIT_BUS, 1'b1}},
        // Program with all-ones, all-zeros and alternating patterns.
        '{KIND_PROGRAM, 17'h1FFFF, 8'hFF, 8'h00, 1'b0, NO_TYPED_WORD},
        '{KIND_PROGRAM, 17'h00000, 8'h00, 8'hFF, 1'b0, NO_TYPED_WORD},
        '{KIND_PROGRAM, 17'h0AAAA, 8'h55, 8'h00, 1'b0, NO_TYPED_WORD},
        // Sector erase at the first and last legal sector, then just past the
        // limit and at the top of the field, which must both be rejected.
        '{KIND_SECTOR_ERASE, 17'h1FFFF, 8'hFF, 8'h00, 1'b0, NO_TYPED_WORD},
        '{KIND_SECTOR_ERASE, 17'h00000, 8'h00, 8'h1F, 1'b0, NO_TYPED_WORD},
        '{KIND_SECTOR_ERASE, 17'h00000, 8'h00, 8'h20, 1'b1, REJECTED_WORD},
        '{KIND_SECTOR_ERASE, 17'h1FFFF, 8'hFF, 8'hFF, 1'b1, REJECTED_WORD},
        '{KIND_CHIP_ERASE, 17'h15555, 8'hAA, 8'h55, 1'b0, NO_TYPED_WORD},
        '{KIND_READ_ID, 17'h1FFFF, 8'hFF, 8'hFF, 1'b0, NO_TYPED_WORD},
        '{KIND_READ_ID, 17'h00000, 8'h00, 8'h00, 1'b0, NO_TYPED_WORD},
        // Undefined kinds, each rejected regardless of the other fields.
        '{KIND_RESERVED_LO, 17'h1FFFF, 8'hFF, 8'hFF, 1'b1, REJECTED_WORD},
        '{KIND_RESERVED_MID, 17'h0AAAA, 8'h55, 8'h0A, 1'b1, REJECTED_WORD},
        '{KIND_RESERVED_HI, 17'h00000, 8'h00, 8'h00, 1'b1, REJECTED_WORD},
        '{KIND_READ, 17'h15555, 8'hAA, 8'h55, 1'b0, NO_TYPED_WORD}
    };

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic cyc_t flash_cycle(logic [1:0] kind, logic [ADDR_W-1:0] addr,
                                         logic [BYTE_W-1:0] data, logic [1:0] tag,
                                         logic [WAIT_W-1:0] wait_time, logic last);
        cyc_t c;
        c.cycle_kind  = kind;
        c.bus_address = addr;
        c.bus_data    = data;
        c.capture_tag = tag;
        c.wait_us     = wait_time;
        c.last_cycle  = last;
        return c;
    endfunction

    function automatic cyc_t flash_write_cycle(logic [ADDR_W-1:0] addr, logic [BYTE_W-1:0] data,
                                               logic [WAIT_W-1:0] wait_time, logic last);
        return flash_cycle(CK_WRITE, addr, data, TAG_NONE, wait_time, last);
    endfunction

    // The five writes that open both erase commands.
    function automatic void append_erase_unlock(ref cyc_t burst [$]);
        burst.push_back(flash_write_cycle(UNLOCK_A, CMD_UNLOCK_1, WAIT_BUS, 1'b0));
        burst.push_back(flash_write_cycle(UNLOCK_B, CMD_UNLOCK_2, WAIT_BUS, 1'b0));
        burst.push_back(flash_write_cycle(UNLOCK_A, CMD_ERASE, WAIT_BUS, 1'b0));
        burst.push_back(flash_write_cycle(UNLOCK_A, CMD_UNLOCK_1, WAIT_BUS, 1'b0));
        burst.push_back(flash_write_cycle(UNLOCK_B, CMD_UNLOCK_2, WAIT_BUS, 1'b0));
    endfunction

    // Works out the bus cycles that one request expands into.
    function automatic void predict_bus_cycles(logic [KIND_W-1:0] kind,
                                               logic [ADDR_W-1:0] addr,
                                               logic [BYTE_W-1:0] data,
                                               logic [SECTOR_W-1:0] sector,
                                               ref cyc_t burst [$]);
        logic [ADDR_W-1:0] erase_addr;
        // Only the bits of the shifted sector that fit the address width survive.
        erase_addr = ADDR_W'(32'(sector) << ERASE_SHIFT);
        case (kind)
            KIND_READ:
                burst.push_back(flash_cycle(CK_READ, addr, '0, TAG_READ_DATA, WAIT_BUS, 1'b1));
            KIND_PROGRAM:
            begin
                burst.push_back(flash_write_cycle(UNLOCK_A, CMD_UNLOCK_1, WAIT_BUS, 1'b0));
                burst.push_back(flash_write_cycle(UNLOCK_B, CMD_UNLOCK_2, WAIT_BUS, 1'b0));
                burst.push_back(flash_write_cycle(UNLOCK_A, CMD_PROGRAM, WAIT_BUS, 1'b0));
                burst.push_back(flash_write_cycle(addr, data, WAIT_PROGRAM, 1'b1));
            end
            KIND_SECTOR_ERASE:
            begin
                if (sector > SECTOR_W'(sector_limit))
                begin
                    burst.push_back(REJECTED_WORD);
                end
                else
                begin
                    append_erase_unlock(burst);
                    burst.push_back(flash_write_cycle(erase_addr, CMD_SECTOR, WAIT_SECTOR,
                                                      1'b1));
                end
            end
            KIND_CHIP_ERASE:
            begin
                append_erase_unlock(burst);
                burst.push_back(flash_write_cycle(UNLOCK_A, CMD_CHIP, WAIT_CHIP, 1'b1));
            end
            KIND_READ_ID:
            begin
                burst.push_back(flash_write_cycle(UNLOCK_A, CMD_UNLOCK_1, WAIT_BUS, 1'b0));
                burst.push_back(flash_write_cycle(UNLOCK_B, CMD_UNLOCK_2, WAIT_BUS, 1'b0));
                burst.push_back(flash_write_cycle(UNLOCK_A, CMD_ID_ENTRY, WAIT_PROGRAM, 1'b0));
                burst.push_back(flash_cycle(CK_READ, ID_ADDR_SW, '0, TAG_SW_ID, WAIT_BUS, 1'b0));
                burst.push_back(flash_cycle(CK_READ, ID_ADDR_DEV, '0, TAG_DEV_ID, WAIT_BUS,
                                            1'b0));
                burst.push_back(flash_write_cycle(UNLOCK_A, CMD_UNLOCK_1, WAIT_BUS, 1'b0));
                burst.push_back(flash_write_cycle(UNLOCK_B, CMD_UNLOCK_2, WAIT_BUS, 1'b0));
                burst.push_back(flash_write_cycle(UNLOCK_A, CMD_ID_EXIT, WAIT_BUS, 1'b1));
            end
            default:
                burst.push_back(REJECTED_WORD);
        endcase
    endfunction

    function automatic void compare_field(string field, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            $error("%s mismatch: expected 0x%0h, actual 0x%0h", field, want, got);
            mismatches++;
        end
    endfunction

    // Monitor for both channels. A request accepted at this edge is predicted before
    // any output word is checked, so a word can never overtake its own expectation.
    // Outputs are read right at the edge, before the block's own updates land.
    always @(posedge clk)
    begin : bus_cycle_monitor
        cyc_t burst [$];
        cyc_t want;
        if (rst_n && req_if.valid && req_if.ready)
        begin
            burst.delete();
            predict_bus_cycles(req_if.kind, req_if.target_address, req_if.write_byte,
                               req_if.sector_number, burst);
            if (row_typed)
                owed_bus_cycles.push_back(row_word);
            else
                foreach (burst[i])
                    owed_bus_cycles.push_back(burst[i]);
            requests_seen++;
            kind_seen[req_if.kind]++;
        end
        if (rst_n && cyc_if.valid && cyc_if.ready)
        begin
            words_checked++;
            if (owed_bus_cycles.size() == 0)
            begin
                $error("bus cycle word with nothing expected: kind %0d, address 0x%0h",
                       cyc_if.cycle_kind, cyc_if.bus_address);
                mismatches++;
            end
            else
            begin
                want = owed_bus_cycles.pop_front();
                compare_field("cycle_kind", 32'(want.cycle_kind), 32'(cyc_if.cycle_kind));
                compare_field("bus_address", 32'(want.bus_address), 32'(cyc_if.bus_address));
                compare_field("bus_data", 32'(want.bus_data), 32'(cyc_if.bus_data));
                compare_field("capture_tag", 32'(want.capture_tag), 32'(cyc_if.capture_tag));
                compare_field("wait_us", 32'(want.wait_us), 32'(cyc_if.wait_us));
                compare_field("last_cycle", 32'(want.last_cycle), 32'(cyc_if.last_cycle));
            end
        end
        // The receiver stalls at random in the share of cycles the current phase asks for.
        cyc_if.ready <= rst_n && ($urandom_range(99) >= receiver_idle_pct);
    end

    // Watchdog: a long run of cycles in which no word moves on either channel ends
    // the run as a hang.
    always @(posedge clk)
    begin
        if (!rst_n || (req_if.valid && req_if.ready) || (cyc_if.valid && cyc_if.ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles == STALL_LIMIT)
        begin
            $display("No word moved for %0d cycles; %0d bus cycle words still owed.",
                     STALL_LIMIT, owed_bus_cycles.size());
            $display("tb: failure");
            $finish;
        end
    end

    // Offers one request word and returns at the edge where it is taken. The valid
    // stays high when the next request follows without a gap.
    task automatic send_request(input logic [KIND_W-1:0] kind,
                                input logic [ADDR_W-1:0] addr,
                                input logic [BYTE_W-1:0] data,
                                input logic [SECTOR_W-1:0] sector,
                                input logic typed, input cyc_t typed_word);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            req_if.valid <= 1'b0;
            @(posedge clk);
        end
        req_if.valid          <= 1'b1;
        req_if.kind           <= kind;
        req_if.target_address <= addr;
        req_if.write_byte     <= data;
        req_if.sector_number  <= sector;
        row_typed             <= typed;
        row_word              <= typed_word;
        do
            @(posedge clk);
        while (!req_if.ready);
    endtask

    // One APB transfer to the last_sector register: setup cycle, then access cycle
    // held until pready.
    task automatic apb_transfer(input logic write, input logic [31:0] data,
                                output logic [31:0] read_value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= write;
        paddr   <= REG_LAST_SECTOR;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        read_value = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Writes last_sector, reads it back, and moves the bench copy along with it.
    task automatic set_sector_limit(input logic [LAST_SECTOR_W-1:0] value);
        logic [31:0] read_value;
        apb_transfer(1'b1, 32'(value), read_value);
        sector_limit = value;
        @(posedge clk);
        apb_transfer(1'b0, '0, read_value);
        if (read_value !== 32'(value))
        begin
            $error("last_sector readback mismatch: expected 0x%0h, actual 0x%0h",
                   value, read_value);
            mismatches++;
        end
    endtask

    // Holds until every owed word has come out; the block is idle after that since
    // every request yields at least one word. The first edge lets the monitor book
    // a request taken at the edge where this task was entered.
    task automatic drain_owed_words();
        @(posedge clk);
        while (owed_bus_cycles.size() != 0)
            @(posedge clk);
    endtask

    // Random requests. Most are legal kinds with in-range sectors so the long
    // sequences run often; the rest draw an undefined kind or an arbitrary sector, and
    // the arbitrary sectors also reach every bit of the sector field.
    task automatic send_random_requests(input int count);
        logic [KIND_W-1:0]   kind;
        logic [SECTOR_W-1:0] sector;
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(99) < 8)
                kind = KIND_W'($urandom_range(KIND_RESERVED_HI, KIND_RESERVED_LO));
            else
                kind = KIND_W'($urandom_range(KIND_READ_ID, KIND_READ));
            if ($urandom_range(99) < 70)
                sector = SECTOR_W'($urandom_range(sector_limit));
            else
                sector = SECTOR_W'($urandom_range(255));
            send_request(kind, ADDR_W'($urandom()), BYTE_W'($urandom()), sector,
                         1'b0, NO_TYPED_WORD);
        end
        req_if.valid <= 1'b0;
    endtask

    initial
    begin
        // Every input is known from time zero.
        req_if.valid          = 1'b0;
        req_if.kind           = KIND_READ;
        req_if.target_address = '0;
        req_if.write_byte     = '0;
        req_if.sector_number  = '0;
        cyc_if.ready          = 1'b0;
        psel                  = 1'b0;
        penable               = 1'b0;
        pwrite                = 1'b0;
        paddr                 = REG_LAST_SECTOR;
        pwdata                = '0;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Directed table at the reset value of last_sector, sender idling 29 percent of
        // the time and receiver 50 percent.
        sender_idle_pct   = 29;
        receiver_idle_pct = 50;
        foreach (directed_rows[i])
            send_request(directed_rows[i].kind, directed_rows[i].target_address,
                         directed_rows[i].write_byte, directed_rows[i].sector_number,
                         directed_rows[i].typed_word, directed_rows[i].word);
        req_if.valid <= 1'b0;
        drain_owed_words();

        // Same stall mix, with a limit somewhere between the extremes.
        set_sector_limit(LAST_SECTOR_W'($urandom_range(30, 1)));
        send_random_requests(RANDOM_PER_PHASE);
        drain_owed_words();

        // Stall mix swapped, and only sector zero may be erased.
        sender_idle_pct   = 50;
        receiver_idle_pct = 29;
        set_sector_limit(SECTOR_LIMIT_MIN);
        send_random_requests(RANDOM_PER_PHASE);
        drain_owed_words();

        // Full rate on both sides with the widest limit, written back explicitly.
        sender_idle_pct   = 0;
        receiver_idle_pct = 0;
        set_sector_limit(SECTOR_LIMIT_MAX);
        send_random_requests(RANDOM_PER_PHASE);
        drain_owed_words();

        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Ran %0d requests (read %0d, program %0d, sector erase %0d, chip erase %0d,",
                 requests_seen, kind_seen[KIND_READ], kind_seen[KIND_PROGRAM],
                 kind_seen[KIND_SECTOR_ERASE], kind_seen[KIND_CHIP_ERASE]);
        $display("read ID %0d, undefined %0d) and checked %0d bus cycle words over four %s",
                 kind_seen[KIND_READ_ID], kind_seen[KIND_RESERVED_LO]
                 + kind_seen[KIND_RESERVED_MID] + kind_seen[KIND_RESERVED_HI], words_checked,
                 "sector limits.");
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
